// ===== rtl/least_loaded_row_assigner_assert.svh =====
// assertion macros used by the checker file
`ifndef LEAST_LOADED_ROW_ASSIGNER_ASSERT_SVH
`define LEAST_LOADED_ROW_ASSIGNER_ASSERT_SVH

// condition at this edge implies consequence at the same edge
`define LLRA_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("llra assertion failed");

// condition at this edge implies consequence at the next edge
`define LLRA_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("llra assertion failed");

`endif

// ===== rtl/llra_pkg.sv =====
package llra_pkg;

  localparam int MAX_PES    = 8;
  localparam int PE_W       = (MAX_PES > 1) ? $clog2(MAX_PES) : 1;
  localparam int TREE_LVLS  = $clog2(MAX_PES);
  localparam int TREE_LEAVES = 1 << TREE_LVLS;

  localparam int LOAD_W     = 32;
  localparam int SLOT_W     = 20;
  localparam int ROW_W      = 20;
  localparam int ITEM_W     = 20;
  localparam int WEIGHT_W   = 16;
  localparam int PE_OUT_W   = 3;
  localparam int ACT_W      = 4;
  localparam int BLK_W      = 8;
  localparam int CMP_W      = (PE_W + 1 > ACT_W) ? PE_W + 1 : ACT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS = 2'd1;

  localparam logic [ACT_W-1:0]  ACTIVE_PES_RST = 4'd8;
  localparam logic [BLK_W-1:0]  BLOCK_ROWS_RST = 8'd1;
  localparam logic [LOAD_W-1:0] LOAD_MAX       = '1;

  typedef struct packed {
    logic [ITEM_W-1:0]   item_index;
    logic [WEIGHT_W-1:0] weight;
    logic                new_group;
  } in_t;

  typedef struct packed {
    logic [PE_OUT_W-1:0] pe;
    logic [SLOT_W-1:0]   slot;
    logic [ROW_W-1:0]    row_start;
    logic                load_saturated;
  } out_t;

  // one node of the argmin tree
  typedef struct packed {
    logic              vld;
    logic [LOAD_W-1:0] load;
    logic [PE_W-1:0]   idx;
  } node_t;

endpackage

// ===== rtl/llra_argmin.sv =====
module llra_argmin (
  input  logic [llra_pkg::LOAD_W-1:0] load_i [llra_pkg::MAX_PES],
  input  logic [llra_pkg::MAX_PES-1:0] active_i,
  output logic [llra_pkg::PE_W-1:0]    best_o
);

  llra_pkg::node_t nodes [llra_pkg::TREE_LVLS+1][llra_pkg::TREE_LEAVES];

  // binary tree; left child wins ties so the lowest index is kept
  always_comb begin
    for (int lv = 0; lv <= llra_pkg::TREE_LVLS; lv++) begin
      for (int n = 0; n < llra_pkg::TREE_LEAVES; n++) begin
        nodes[lv][n] = '0;
      end
    end
    for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
      nodes[0][i].vld  = active_i[i];
      nodes[0][i].load = load_i[i];
      nodes[0][i].idx  = llra_pkg::PE_W'(i);
    end
    for (int lv = 0; lv < llra_pkg::TREE_LVLS; lv++) begin
      for (int n = 0; n < (llra_pkg::TREE_LEAVES >> (lv + 1)); n++) begin
        if (nodes[lv][2*n+1].vld &&
            (!nodes[lv][2*n].vld || (nodes[lv][2*n+1].load < nodes[lv][2*n].load))) begin
          nodes[lv+1][n] = nodes[lv][2*n+1];
        end else begin
          nodes[lv+1][n] = nodes[lv][2*n];
        end
      end
    end
  end

  assign best_o = nodes[llra_pkg::TREE_LVLS][0].idx;

endmodule

// ===== rtl/llra_core.sv =====
module llra_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_i,
  input  llra_pkg::in_t               item_i,
  input  logic [llra_pkg::ACT_W-1:0]  active_pes_i,
  input  logic [llra_pkg::BLK_W-1:0]  block_rows_i,
  output llra_pkg::out_t              res_o
);

  logic [llra_pkg::LOAD_W-1:0] load_r   [llra_pkg::MAX_PES];
  logic [llra_pkg::LOAD_W-1:0] load_nxt [llra_pkg::MAX_PES];
  logic [llra_pkg::SLOT_W-1:0] slot_r   [llra_pkg::MAX_PES];
  logic [llra_pkg::SLOT_W-1:0] slot_nxt [llra_pkg::MAX_PES];
  logic [llra_pkg::LOAD_W-1:0] load_eff [llra_pkg::MAX_PES];
  logic [llra_pkg::SLOT_W-1:0] slot_eff [llra_pkg::MAX_PES];
  logic [llra_pkg::MAX_PES-1:0] active;
  logic [llra_pkg::PE_W-1:0]    best;
  logic [llra_pkg::BLK_W-1:0]   blk;
  logic [llra_pkg::LOAD_W:0]    sum;
  logic                         sat;
  logic [llra_pkg::LOAD_W-1:0]  new_load;
  logic [llra_pkg::ITEM_W+llra_pkg::BLK_W-1:0] row_full;

  assign blk = (block_rows_i == '0) ? llra_pkg::BLK_W'(1) : block_rows_i;

  // new group clears everything before the pick
  always_comb begin
    for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
      load_eff[i] = item_i.new_group ? '0 : load_r[i];
      slot_eff[i] = item_i.new_group ? '0 : slot_r[i];
      active[i]   = (i == 0) ||
                    (llra_pkg::CMP_W'(active_pes_i) > llra_pkg::CMP_W'(i));
    end
  end

  llra_argmin u_argmin (
    .load_i   (load_eff),
    .active_i (active),
    .best_o   (best)
  );

  assign sum      = {1'b0, load_eff[best]} + (llra_pkg::LOAD_W+1)'(item_i.weight);
  assign sat      = sum[llra_pkg::LOAD_W];
  assign new_load = sat ? llra_pkg::LOAD_MAX : sum[llra_pkg::LOAD_W-1:0];
  assign row_full = (llra_pkg::ITEM_W+llra_pkg::BLK_W)'(item_i.item_index) *
                    (llra_pkg::ITEM_W+llra_pkg::BLK_W)'(blk);

  always_comb begin
    for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
      if (llra_pkg::PE_W'(i) == best) begin
        load_nxt[i] = new_load;
        slot_nxt[i] = slot_eff[i] + llra_pkg::SLOT_W'(blk);
      end else begin
        load_nxt[i] = load_eff[i];
        slot_nxt[i] = slot_eff[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
        load_r[i] <= '0;
        slot_r[i] <= '0;
      end
    end else if (step_i) begin
      for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
        load_r[i] <= load_nxt[i];
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  assign res_o.pe             = llra_pkg::PE_OUT_W'(best);
  assign res_o.slot           = slot_eff[best];
  assign res_o.row_start      = row_full[llra_pkg::ROW_W-1:0];
  assign res_o.load_saturated = sat;

endmodule

// ===== rtl/least_loaded_row_assigner.sv =====
// the input word is held in the input reg, then its result word in the result reg
// throughput: one word per cycle unless a result word is held by out_stall; the argmin
// tree, add and load write-back are combinational, so the next item sees the loads left
// by the previous one with no bubble
// reset (rst_n low, synchronous): loads and slot counts cleared, pipeline emptied,
// active_pes back to 8 and block_rows back to 1
module least_loaded_row_assigner (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  llra_pkg::in_t                      in_data,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output llra_pkg::out_t                     out_data,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [llra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [llra_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // input register stage
  logic          a_valid_r;
  llra_pkg::in_t a_data_r;
  // result register stage
  logic           out_valid_r;
  llra_pkg::out_t out_data_r;
  llra_pkg::out_t res;
  // configuration registers
  logic [llra_pkg::ACT_W-1:0] active_pes_r;
  logic [llra_pkg::BLK_W-1:0] block_rows_r;

  logic res_ready;   // result register can take a word this cycle
  logic advance;     // item in input register is assigned and moves on
  logic accept;      // new input word captured

  // result register frees up when empty or when its word is being taken
  assign res_ready = !out_valid_r || !out_stall;
  assign advance   = a_valid_r && res_ready;
  // input register is free when empty or when it moves on this cycle
  assign in_stall  = a_valid_r && !res_ready;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data_r <= in_data;
    end
  end

  // assignment logic and the per-element load and slot state; state only
  // moves when an item is actually handed on, so stalls never repeat work
  llra_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (advance),
    .item_i       (a_data_r),
    .active_pes_i (active_pes_r),
    .block_rows_i (block_rows_r),
    .res_o        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_pes_r <= llra_pkg::ACTIVE_PES_RST;
      block_rows_r <= llra_pkg::BLOCK_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        llra_pkg::CFG_ACTIVE_PES: begin
          active_pes_r <= cfg_data[llra_pkg::ACT_W-1:0];
        end
        llra_pkg::CFG_BLOCK_ROWS: begin
          block_rows_r <= cfg_data[llra_pkg::BLK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/llra_checker.sv =====
`include "least_loaded_row_assigner_assert.svh"

module llra_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input llra_pkg::out_t out_data
);

  // a held result word stays offered
  `LLRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // and does not change while held
  `LLRA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // input side only backs up when a result word is stuck
  `LLRA_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // input released from backpressure: a result word is still there to take
  `LLRA_ASSERT_SAME(a_release, clk, rst_n, $fell(in_stall) && $past(rst_n), out_valid)

endmodule

bind least_loaded_row_assigner llra_checker u_llra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // kinds of line in the directed plan
  typedef enum logic [1:0] {
    ROW_WORD,
    REG_WRITE
  } plan_kind_t;

  typedef struct {
    plan_kind_t                          kind;
    logic [llra_pkg::CFG_IDX_W-1:0]      reg_idx;
    logic [llra_pkg::CFG_DATA_W-1:0]     reg_val;
    llra_pkg::in_t                       row;
    bit                                  known;
    llra_pkg::out_t                      known_res;
  } plan_line_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  llra_pkg::in_t                     in_data = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  llra_pkg::out_t                    out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [llra_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [llra_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // when set, neither side idles
  bit calm = 1'b0;

  // shadow of the assigner: per-element load and slot count plus both registers
  logic [llra_pkg::LOAD_W-1:0]       load_acc [llra_pkg::MAX_PES];
  logic [llra_pkg::SLOT_W-1:0]       slot_acc [llra_pkg::MAX_PES];
  logic [llra_pkg::ACT_W-1:0]        act_cfg;
  logic [llra_pkg::BLK_W-1:0]        blk_cfg;

  // assignments predicted for accepted rows, oldest first
  llra_pkg::out_t                    pending_assignments [$];
  int                                mismatches = 0;

  plan_line_t                        plan [$];

  least_loaded_row_assigner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

  // greedy pick: least loaded active element, lowest index on a tie
  function automatic llra_pkg::out_t predict_assignment(llra_pkg::in_t w);
    llra_pkg::out_t                    r;
    int                                n;
    int                                best;
    logic [llra_pkg::BLK_W-1:0]        blk;
    logic [llra_pkg::LOAD_W:0]         sum;
    logic [llra_pkg::ROW_W+llra_pkg::BLK_W-1:0] prod;
    n = int'(act_cfg);
    if (n == 0) n = 1;
    if (n > llra_pkg::MAX_PES) n = llra_pkg::MAX_PES;
    blk = (blk_cfg == '0) ? llra_pkg::BLK_W'(1) : blk_cfg;
    // a new colour wipes every element, active or not
    if (w.new_group) begin
      for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
        load_acc[i] = '0;
        slot_acc[i] = '0;
      end
    end
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (load_acc[i] < load_acc[best]) best = i;
    end
    sum = {1'b0, load_acc[best]} + (llra_pkg::LOAD_W+1)'(w.weight);
    r.load_saturated = sum[llra_pkg::LOAD_W];
    load_acc[best] = sum[llra_pkg::LOAD_W] ? llra_pkg::LOAD_MAX : sum[llra_pkg::LOAD_W-1:0];
    r.pe = best[llra_pkg::PE_OUT_W-1:0];
    r.slot = slot_acc[best];
    prod = (llra_pkg::ROW_W+llra_pkg::BLK_W)'(w.item_index) *
           (llra_pkg::ROW_W+llra_pkg::BLK_W)'(blk);
    r.row_start = prod[llra_pkg::ROW_W-1:0];
    slot_acc[best] = slot_acc[best] + llra_pkg::SLOT_W'(blk);
    return r;
  endfunction

  function automatic plan_line_t row_line(logic [llra_pkg::ITEM_W-1:0] idx,
                                          logic [llra_pkg::WEIGHT_W-1:0] wt,
                                          logic ng, bit known,
                                          logic [llra_pkg::PE_OUT_W-1:0] pe,
                                          logic [llra_pkg::SLOT_W-1:0] slot,
                                          logic [llra_pkg::ROW_W-1:0] rs,
                                          logic sat);
    plan_line_t l;
    l.kind = ROW_WORD;
    l.reg_idx = '0;
    l.reg_val = '0;
    l.row = '{item_index: idx, weight: wt, new_group: ng};
    l.known = known;
    l.known_res = '{pe: pe, slot: slot, row_start: rs, load_saturated: sat};
    return l;
  endfunction

  function automatic plan_line_t reg_line(logic [llra_pkg::CFG_IDX_W-1:0] idx,
                                          logic [llra_pkg::CFG_DATA_W-1:0] val);
    plan_line_t l;
    l.kind = REG_WRITE;
    l.reg_idx = idx;
    l.reg_val = val;
    l.row = '0;
    l.known = 1'b0;
    l.known_res = '0;
    return l;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
  endtask

  // offer one row word, predict its assignment once it is taken
  task automatic send_row(input llra_pkg::in_t w, input bit known,
                          input llra_pkg::out_t known_res);
    llra_pkg::out_t predicted;
    cfg_valid <= 1'b0;
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_assignment(w);
    pending_assignments.push_back(known ? known_res : predicted);
  endtask

  // stop offering and let every expected result drain out
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register word; cfg_valid stays up so back-to-back writes are seamless
  task automatic write_reg(input logic [llra_pkg::CFG_IDX_W-1:0] idx,
                           input logic [llra_pkg::CFG_DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < 26) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      llra_pkg::CFG_ACTIVE_PES: act_cfg = val[llra_pkg::ACT_W-1:0];
      llra_pkg::CFG_BLOCK_ROWS: blk_cfg = val[llra_pkg::BLK_W-1:0];
      default: ;  // unknown index, nothing changes
    endcase
  endtask

  // receiver back-pressure, off during reset and during the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  // result checker: each taken result word against the oldest prediction
  always @(posedge clk) begin
    llra_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_assignments.size() == 0) begin
        flag_mismatch("unexpected result word", '0, 64'(out_data));
      end else begin
        want = pending_assignments.pop_front();
        if (out_data.pe !== want.pe)
          flag_mismatch("pe", 64'(want.pe), 64'(out_data.pe));
        if (out_data.slot !== want.slot)
          flag_mismatch("slot", 64'(want.slot), 64'(out_data.slot));
        if (out_data.row_start !== want.row_start)
          flag_mismatch("row_start", 64'(want.row_start), 64'(out_data.row_start));
        if (out_data.load_saturated !== want.load_saturated)
          flag_mismatch("load_saturated", 64'(want.load_saturated),
                        64'(out_data.load_saturated));
      end
    end
  end

  initial begin
    llra_pkg::in_t                   w;
    logic [llra_pkg::ACT_W-1:0]      act_pick;
    logic [llra_pkg::BLK_W-1:0]      blk_pick;
    logic [llra_pkg::ITEM_W-1:0]     next_row;
    int                              phase_rows;

    // shadow starts from the reset state
    for (int i = 0; i < llra_pkg::MAX_PES; i++) begin
      load_acc[i] = '0;
      slot_acc[i] = '0;
    end
    act_cfg = llra_pkg::ACTIVE_PES_RST;
    blk_cfg = llra_pkg::BLOCK_ROWS_RST;
    next_row = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan: reset values, field extremes, register corner values
    // all loads zero, so element 0 wins the tie
    plan.push_back(row_line(20'h00000, 16'h0000, 1'b0, 1, 3'd0, 20'd0, 20'h00000, 1'b0));
    // element 0 still at zero load, second slot
    plan.push_back(row_line(20'hFFFFF, 16'hFFFF, 1'b0, 1, 3'd0, 20'd1, 20'hFFFFF, 1'b0));
    plan.push_back(row_line(20'h00005, 16'h0001, 1'b0, 1, 3'd1, 20'd0, 20'h00005, 1'b0));
    // new colour clears everything first
    plan.push_back(row_line(20'h00006, 16'hFFFF, 1'b1, 1, 3'd0, 20'd0, 20'h00006, 1'b0));
    plan.push_back(row_line(20'h00001, 16'h000A, 1'b0, 1, 3'd1, 20'd0, 20'h00001, 1'b0));
    // single element, upper data bits ignored
    plan.push_back(reg_line(llra_pkg::CFG_ACTIVE_PES, 8'hF1));
    plan.push_back(row_line(20'h00002, 16'h0014, 1'b0, 1, 3'd0, 20'd1, 20'h00002, 1'b0));
    // zero active elements behaves as one
    plan.push_back(reg_line(llra_pkg::CFG_ACTIVE_PES, 8'h00));
    plan.push_back(row_line(20'h00003, 16'h0000, 1'b0, 1, 3'd0, 20'd2, 20'h00003, 1'b0));
    // too many active elements clamps to the maximum
    plan.push_back(reg_line(llra_pkg::CFG_ACTIVE_PES, 8'h0F));
    plan.push_back(row_line(20'h00004, 16'h0005, 1'b0, 0, '0, '0, '0, 1'b0));
    plan.push_back(reg_line(llra_pkg::CFG_ACTIVE_PES, 8'h09));
    plan.push_back(row_line(20'h00008, 16'h0003, 1'b0, 0, '0, '0, '0, 1'b0));
    // zero block size behaves as one
    plan.push_back(reg_line(llra_pkg::CFG_BLOCK_ROWS, 8'h00));
    plan.push_back(row_line(20'h12345, 16'h0007, 1'b1, 1, 3'd0, 20'd0, 20'h12345, 1'b0));
    // largest legal block, row number wraps
    plan.push_back(reg_line(llra_pkg::CFG_BLOCK_ROWS, 8'h80));
    plan.push_back(row_line(20'hFFFFF, 16'h0009, 1'b0, 0, '0, '0, '0, 1'b0));
    // block size above range used as written
    plan.push_back(reg_line(llra_pkg::CFG_BLOCK_ROWS, 8'hFF));
    plan.push_back(row_line(20'h01000, 16'hFFFF, 1'b0, 0, '0, '0, '0, 1'b0));
    // unknown register indexes change nothing
    plan.push_back(reg_line(2'd2, 8'h55));
    plan.push_back(reg_line(2'd3, 8'hAA));
    plan.push_back(row_line(20'h00007, 16'h0003, 1'b0, 0, '0, '0, '0, 1'b0));
    // shrink to three: loaded elements above the count are skipped, kept intact
    plan.push_back(reg_line(llra_pkg::CFG_ACTIVE_PES, 8'h03));
    plan.push_back(row_line(20'h00010, 16'h0002, 1'b0, 0, '0, '0, '0, 1'b0));
    plan.push_back(row_line(20'h00011, 16'h0002, 1'b0, 0, '0, '0, '0, 1'b0));
    plan.push_back(row_line(20'h00012, 16'h0100, 1'b0, 0, '0, '0, '0, 1'b0));
    plan.push_back(row_line(20'h00013, 16'h0001, 1'b0, 0, '0, '0, '0, 1'b0));
    plan.push_back(reg_line(llra_pkg::CFG_ACTIVE_PES, 8'h08));
    plan.push_back(row_line(20'h00014, 16'h0001, 1'b0, 0, '0, '0, '0, 1'b0));
    plan.push_back(row_line(20'h00015, 16'h0001, 1'b1, 0, '0, '0, '0, 1'b0));
    plan.push_back(reg_line(llra_pkg::CFG_BLOCK_ROWS, 8'h01));
    plan.push_back(row_line(20'h00016, 16'h8000, 1'b0, 0, '0, '0, '0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == REG_WRITE) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_row(plan[i].row, plan[i].known, plan[i].known_res);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      calm = (ph == 5);
      case (ph)
        0: act_pick = 4'd1;
        1: act_pick = 4'd8;
        default: begin
          case ($urandom_range(5))
            0: act_pick = 4'd1;
            1: act_pick = 4'd8;
            2: act_pick = llra_pkg::ACT_W'($urandom_range(15));
            default: act_pick = llra_pkg::ACT_W'($urandom_range(8, 1));
          endcase
        end
      endcase
      case (ph)
        0: blk_pick = 8'd1;
        1: blk_pick = 8'd128;
        default: begin
          case ($urandom_range(5))
            0: blk_pick = 8'd1;
            1: blk_pick = 8'd128;
            2: blk_pick = 8'd0;
            3: blk_pick = 8'd255;
            4: blk_pick = llra_pkg::BLK_W'($urandom_range(255));
            default: blk_pick = llra_pkg::BLK_W'($urandom_range(128, 1));
          endcase
        end
      endcase
      // upper data bits of the element count are junk
      write_reg(llra_pkg::CFG_ACTIVE_PES, {4'($urandom_range(15)), act_pick});
      write_reg(llra_pkg::CFG_BLOCK_ROWS, blk_pick);
      if ($urandom_range(3) == 0)
        write_reg(llra_pkg::CFG_IDX_W'($urandom_range(3, 2)),
                  llra_pkg::CFG_DATA_W'($urandom));
      phase_rows = $urandom_range(100, 80);
      for (int k = 0; k < phase_rows; k++) begin
        // mostly rows in order, as a colour is walked; some scattered
        if ($urandom_range(3) == 0) w.item_index = llra_pkg::ITEM_W'($urandom);
        else w.item_index = next_row;
        next_row = next_row + llra_pkg::ITEM_W'(1);
        case ($urandom_range(3))
          0: w.weight = llra_pkg::WEIGHT_W'($urandom_range(15));
          1: w.weight = llra_pkg::WEIGHT_W'($urandom);
          2: w.weight = $urandom_range(1) ? '1 : '0;
          default: w.weight = llra_pkg::WEIGHT_W'($urandom_range(16'hFFFF, 16'hFF00));
        endcase
        w.new_group = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
        send_row(w, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // one element, a run of the heaviest rows in a large block
    settle();
    write_reg(llra_pkg::CFG_ACTIVE_PES, 8'h01);
    write_reg(llra_pkg::CFG_BLOCK_ROWS, 8'hFF);
    for (int k = 0; k < 24; k++) begin
      w.item_index = llra_pkg::ITEM_W'($urandom);
      w.weight = '1;
      w.new_group = (k == 0);
      send_row(w, 1'b0, '0);
    end
    // zero weight leaves the load where it is
    w.item_index = llra_pkg::ITEM_W'($urandom);
    w.weight = '0;
    w.new_group = 1'b0;
    send_row(w, 1'b0, '0);
    for (int k = 0; k < 8; k++) begin
      w.item_index = llra_pkg::ITEM_W'($urandom);
      w.weight = llra_pkg::WEIGHT_W'($urandom);
      w.new_group = 1'b0;
      send_row(w, 1'b0, '0);
    end
    // a second element joins at zero load and takes the following rows
    settle();
    write_reg(llra_pkg::CFG_ACTIVE_PES, 8'h02);
    for (int k = 0; k < 8; k++) begin
      w.item_index = llra_pkg::ITEM_W'($urandom);
      w.weight = llra_pkg::WEIGHT_W'($urandom);
      w.new_group = 1'b0;
      send_row(w, 1'b0, '0);
    end

    // drain, then stay quiet for any stray word
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_assignments.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
